[design/hdte_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump text encoder package
// Shared item types, line layout constants and the hex digit function.
// ----------------------------------------------------------------------------
package hdte_pkg;

	localparam int BYTES_PER_LINE = 16;
	localparam int POS_W          = $clog2(BYTES_PER_LINE);
	localparam int QUEUE_DEPTH    = 4;

	// Step numbers of the character sequencer. A line header covers steps
	// 0 to 13, the byte itself steps 14 to 16 and the line end 17 and 18.
	localparam int STEP_W         = 5;
	localparam logic [STEP_W-1:0] STEP_HDR_FIRST  = 5'd0;
	localparam logic [STEP_W-1:0] STEP_HDR_LAST_DIGIT = 5'd7;
	localparam logic [STEP_W-1:0] STEP_COLON      = 5'd8;
	localparam logic [STEP_W-1:0] STEP_BYTE_SPACE = 5'd14;
	localparam logic [STEP_W-1:0] STEP_HIGH       = 5'd15;
	localparam logic [STEP_W-1:0] STEP_LOW        = 5'd16;
	localparam logic [STEP_W-1:0] STEP_CR         = 5'd17;
	localparam logic [STEP_W-1:0] STEP_LF         = 5'd18;

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_A     = 8'h41;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [31:0] byte_address;
	} item_t;

	typedef struct packed {
		logic [7:0] text_char;
		logic       last_char;
	} result_t;

	typedef enum logic [1:0] {
		KIND_MID   = 2'd0,
		KIND_OPEN  = 2'd1,
		KIND_CLOSE = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  data_byte;
		logic [31:0] byte_address;
	} cmd_t;

	function automatic logic [7:0] nibble_char(input logic [3:0] n);
		logic [7:0] ch;
		if (n < 4'd10) begin
			ch = CHAR_ZERO + {4'd0, n};
		end else begin
			ch = CHAR_A + {4'd0, n} - 8'd10;
		end
		return ch;
	endfunction

endpackage

[design/hdte_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump front end
// Takes input transactions, classifies the byte by its place in the line and
// hands the command to the queue.
// ----------------------------------------------------------------------------
module hdte_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  hdte_pkg::item_t item,
	output logic           q_push,
	output hdte_pkg::cmd_t q_cmd,
	input  logic           q_full
);
	import hdte_pkg::*;

	logic  valid_s1;
	cmd_t  cmd_s1;
	kind_t kind;
	logic  accept;

	always_comb begin
		kind = KIND_MID;
		if (item.byte_address[POS_W-1:0] == '0) begin
			kind = KIND_OPEN;
		end else if (item.byte_address[POS_W-1:0] == POS_W'(BYTES_PER_LINE - 1)) begin
			kind = KIND_CLOSE;
		end
	end

	assign q_push = valid_s1 && !q_full;
	assign full   = valid_s1 && q_full;
	assign accept = push && !full;
	assign q_cmd  = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (q_push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1.kind         <= kind;
			cmd_s1.data_byte    <= item.data_byte;
			cmd_s1.byte_address <= item.byte_address;
		end
	end

endmodule

[design/hdte_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump command queue
// Small first-in first-out store of classified commands between the front
// end and the character sequencer.
// ----------------------------------------------------------------------------
module hdte_queue #(
	parameter int DEPTH = hdte_pkg::QUEUE_DEPTH
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  hdte_pkg::cmd_t wr_cmd,
	output logic           q_full,
	input  logic           rd,
	output hdte_pkg::cmd_t rd_cmd,
	output logic           q_empty
);
	import hdte_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_full  = (count_q == CNT_W'(DEPTH));
	assign q_empty = (count_q == '0);
	assign rd_cmd  = mem[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] n;
		if (p == PTR_W'(DEPTH - 1)) begin
			n = '0;
		end else begin
			n = p + 1'b1;
		end
		return n;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (rd) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (wr && !rd) begin
				count_q <= count_q + 1'b1;
			end else if (rd && !wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			mem[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

[design/hdte_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump character sequencer
// Steps through the characters of one command at a time and places each in
// the result register.
// ----------------------------------------------------------------------------
module hdte_back (
	input  logic             clk,
	input  logic             arst_n,
	input  hdte_pkg::cmd_t   rd_cmd,
	input  logic             q_empty,
	output logic             rd,
	output logic             empty,
	input  logic             pop,
	output hdte_pkg::result_t result
);
	import hdte_pkg::*;

	cmd_t              cmd_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              advance;
	logic              at_end;
	logic              emit;
	logic [STEP_W-1:0] end_step;
	logic [STEP_W-1:0] start_step;
	logic [2:0]        digit_sel;
	logic [3:0]        hdr_nibble;
	logic [7:0]        ch;

	assign advance  = !out_valid_q || pop;
	assign emit     = busy_q && advance;
	assign end_step = (cmd_q.kind == KIND_CLOSE) ? STEP_LF : STEP_LOW;
	assign at_end   = (step_q == end_step);
	assign rd       = !q_empty && (!busy_q || (emit && at_end));
	assign start_step = (rd_cmd.kind == KIND_OPEN) ? STEP_HDR_FIRST : STEP_BYTE_SPACE;

	// Header digits run from the most significant nibble down.
	assign digit_sel  = 3'(STEP_HDR_LAST_DIGIT - step_q);
	assign hdr_nibble = cmd_q.byte_address[{digit_sel, 2'b00} +: 4];

	always_comb begin
		if (step_q <= STEP_HDR_LAST_DIGIT) begin
			ch = nibble_char(hdr_nibble);
		end else if (step_q == STEP_COLON) begin
			ch = CHAR_COLON;
		end else if (step_q == STEP_HIGH) begin
			ch = nibble_char(cmd_q.data_byte[7:4]);
		end else if (step_q == STEP_LOW) begin
			ch = nibble_char(cmd_q.data_byte[3:0]);
		end else if (step_q == STEP_CR) begin
			ch = CHAR_CR;
		end else if (step_q == STEP_LF) begin
			ch = CHAR_LF;
		end else begin
			ch = CHAR_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (rd) begin
				busy_q <= 1'b1;
				step_q <= start_step;
			end else if (emit) begin
				if (at_end) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + 1'b1;
				end
			end
			if (advance) begin
				out_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			cmd_q <= rd_cmd;
		end
		if (emit) begin
			out_q.text_char <= ch;
			out_q.last_char <= at_end;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

[design/hex_dump_text_encoder_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump text encoder
// Turns bytes with their addresses into hex dump text, 16 bytes per line.
// ----------------------------------------------------------------------------
// Usage: the input side is a queue port. A transaction (push high, full low)
// carries one data byte and its address. The result side is a queue port as
// well: while empty is low the oldest character sits on result, and pop
// takes it. last_char marks the final character of each input byte.
// A byte that opens a line gives 17 characters (address header, colon, five
// spaces, space and two digits), a byte that closes a line gives 5 and any
// other byte gives 3, so a full line averages 4 characters per byte. The
// rate is set by the character sequencer, which writes one character per
// cycle into the result register whenever that register is free or popped.
// An item passes through the input register, the command queue and the
// sequencer's command register before reaching the result register.
// The command queue keeps accepting while the result side stalls; full
// rises only when that queue and the input register are both occupied.
// Reset clears all control state but not the data registers or queue storage.
// ----------------------------------------------------------------------------
module hex_dump_text_encoder_core #(
	parameter int QUEUE_DEPTH = hdte_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  hdte_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output hdte_pkg::result_t result
);
	import hdte_pkg::*;

	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	cmd_t q_wr_cmd;
	cmd_t q_rd_cmd;

	hdte_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_cmd  (q_wr_cmd),
		.q_full (q_full)
	);

	hdte_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_cmd  (q_wr_cmd),
		.q_full  (q_full),
		.rd      (q_pop),
		.rd_cmd  (q_rd_cmd),
		.q_empty (q_empty)
	);

	hdte_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_cmd  (q_rd_cmd),
		.q_empty (q_empty),
		.rd      (q_pop),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	a_queue_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !q_empty)
		else $error("command queue reports full and empty together");

	a_no_read_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("sequencer read from an empty command queue");

	a_no_write_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("front end wrote into a full command queue");

	a_full_needs_queue_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> q_full)
		else $error("input stalled while the command queue had room");

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hex dump text encoder testbench
// Drives bytes with their addresses into the encoder and compares every
// character that comes out with a locally computed dump line. Runs a short
// directed set, then mostly consecutive runs of bytes with random content.
// Both sides idle at random, and the result side holds off once for a long
// stretch so that the encoder fills up and stalls its input.
// ----------------------------------------------------------------------------
module tb;
	import hdte_pkg::*;

	localparam int RANDOM_ITEMS = 480;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 32;
	localparam int MAX_REPORTS  = 10;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    push;
	logic    full;
	item_t   item;
	logic    empty;
	logic    pop;
	result_t result;

	// Holds the characters still to come from the encoder, oldest first.
	class char_scoreboard;
		result_t pending_chars[$];
		int      errors = 0;

		function logic [7:0] hex_ascii(input logic [3:0] n);
			if (n < 4'd10) begin
				return CHAR_ZERO + {4'd0, n};
			end
			return CHAR_A + {4'd0, n} - 8'd10;
		endfunction

		function void add_char(input logic [7:0] ch);
			result_t r;
			r.text_char = ch;
			r.last_char = 1'b0;
			pending_chars.push_back(r);
		endfunction

		function void note_item(input item_t it);
			int pos;
			pos = int'(it.byte_address % BYTES_PER_LINE);
			if (pos == 0) begin
				for (int k = 7; k >= 0; k--) begin
					add_char(hex_ascii(it.byte_address[4*k +: 4]));
				end
				add_char(CHAR_COLON);
				repeat (5) add_char(CHAR_SPACE);
			end
			add_char(CHAR_SPACE);
			add_char(hex_ascii(it.data_byte[7:4]));
			add_char(hex_ascii(it.data_byte[3:0]));
			if (pos == BYTES_PER_LINE - 1) begin
				add_char(CHAR_CR);
				add_char(CHAR_LF);
			end
			pending_chars[pending_chars.size() - 1].last_char = 1'b1;
		endfunction

		function void check_result(input result_t got);
			result_t want;
			if (pending_chars.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("unexpected character %h (last %b) with nothing pending",
						got.text_char, got.last_char);
				end
				return;
			end
			want = pending_chars.pop_front();
			if (got.text_char !== want.text_char || got.last_char !== want.last_char) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("mismatch: expected char %h last %b, got char %h last %b",
						want.text_char, want.last_char, got.text_char, got.last_char);
				end
			end
		endfunction
	endclass

	char_scoreboard sb;
	int             items_sent = 0;
	bit             sender_calm = 1'b0;

	hex_dump_text_encoder_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always #6 clk = ~clk;

	// Both transaction monitors sample at the rising edge.
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			sb.note_item(item);
		end
		if (arst_n && pop && !empty) begin
			sb.check_result(result);
		end
	end

	function item_t make_item(input logic [7:0] data, input logic [31:0] addr);
		item_t it;
		it.data_byte    = data;
		it.byte_address = addr;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_item(input item_t it);
		while (!sender_calm && $urandom_range(99) < 19) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		@(negedge clk);
		items_sent++;
	endtask

	// Result side: random idling, one long hold-off and a stretch with none.
	initial begin
		int rx_cycle;
		int hold_left;
		rx_cycle  = 0;
		hold_left = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			rx_cycle++;
			if (rx_cycle == 700) begin
				hold_left = 400;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (rx_cycle >= 1300 && rx_cycle < 1800) begin
				pop <= 1'b1;
			end else begin
				pop <= ($urandom_range(99) >= 19);
			end
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		logic [31:0] line_base;
		int          start_pos;
		int          run_len;
		int          target;
		sb     = new;
		arst_n = 1'b0;
		push   = 1'b0;
		item   = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: a full line from address zero, field extremes, high
		// addresses, a line end at the top of the address space, and
		// repeated or skipped addresses.
		send_item(make_item(8'h00, 32'h0000_0000));
		send_item(make_item(8'hFF, 32'h0000_0001));
		send_item(make_item(8'h5A, 32'h0000_0002));
		send_item(make_item(8'hA5, 32'h0000_0003));
		send_item(make_item(8'h09, 32'h0000_0004));
		send_item(make_item(8'h0A, 32'h0000_0005));
		send_item(make_item(8'h90, 32'h0000_0006));
		send_item(make_item(8'hA0, 32'h0000_0007));
		send_item(make_item(8'h0F, 32'h0000_0008));
		send_item(make_item(8'hF0, 32'h0000_0009));
		send_item(make_item(8'h12, 32'h0000_000A));
		send_item(make_item(8'h34, 32'h0000_000B));
		send_item(make_item(8'hBC, 32'h0000_000C));
		send_item(make_item(8'hDE, 32'h0000_000D));
		send_item(make_item(8'h78, 32'h0000_000E));
		send_item(make_item(8'hFF, 32'h0000_000F));
		send_item(make_item(8'hFF, 32'hFFFF_FFF0));
		send_item(make_item(8'h00, 32'hFFFF_FFFF));
		send_item(make_item(8'h3C, 32'h89AB_CDE0));
		send_item(make_item(8'hC3, 32'h1234_5670));
		send_item(make_item(8'h55, 32'h7FFF_FFFF));
		send_item(make_item(8'h66, 32'h0000_0005));
		send_item(make_item(8'h66, 32'h0000_0005));
		send_item(make_item(8'hE1, 32'h8000_0000));
		send_item(make_item(8'h1E, 32'hFEDC_BA9F));

		// Mostly consecutive runs through one or more lines, some noise.
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			if ($urandom_range(99) < 20) begin
				send_item(make_item(8'($urandom), $urandom));
			end else begin
				line_base = {28'($urandom), 4'h0};
				start_pos = ($urandom_range(1) == 0) ? 0 : $urandom_range(15);
				run_len   = $urandom_range(40, 1);
				for (int i = 0; i < run_len && items_sent < target; i++) begin
					sender_calm = (items_sent >= 300 && items_sent < 380);
					send_item(make_item(8'($urandom), line_base + start_pos + i));
				end
			end
		end
		sender_calm = 1'b0;
		push <= 1'b0;

		while (sb.pending_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending_chars.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
